// ===== design/sps_pkg.sv =====
`timescale 1ns / 1ps
package sps_pkg;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_SOLVE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [2:0] REG_ROWS      = 3'd0;
	localparam logic [2:0] REG_COLS      = 3'd1;
	localparam logic [2:0] REG_OMEGA     = 3'd2;
	localparam logic [2:0] REG_TOLERANCE = 3'd3;
	localparam logic [2:0] REG_MAX_SWEEP = 3'd4;

	localparam int MAX_STEPS = 64;  // largest grid step count; sets store size
	localparam int STEP_W = 7;   // grid step count register width
	localparam int R2_W   = 14;  // square of a step count
	localparam int D_W    = 17;  // 2(R^2+C^2)
	localparam int MA_W   = 34;  // shared multiplier operand widths
	localparam int MB_W   = 18;
	localparam int P_W    = MA_W + MB_W;
	localparam int S_W    = 52;  // weighted neighbor sum
	localparam int NUM_W  = 70;  // |S|*omega + D/2
	localparam int CFG_W  = 31;

	typedef struct packed {
		logic [1:0]   operation;
		logic [6:0]   row;
		logic [6:0]   col;
		logic signed [31:0] node_value_in;
		logic signed [31:0] source_in;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] node_value_out;
		logic [15:0]  sweeps_done;
		logic [30:0]  last_change;
		logic         converged;
	} res_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_WRITE, ST_READ, ST_READ_WAIT, ST_NOP,
		ST_SETUP, ST_DIAG,
		ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_RD5,
		ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
		ST_DIV, ST_FIN, ST_SWEEP_END
	} state_t;

endpackage

// ===== design/sps_ram.sv =====
`timescale 1ns / 1ps
module sps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4225
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== design/sps_mul.sv =====
`timescale 1ns / 1ps
module sps_mul
	import sps_pkg::*;
(
	input  logic                   clk,
	input  logic signed [MA_W-1:0] a,
	input  logic signed [MB_W-1:0] b,
	output logic signed [P_W-1:0]  p
);
	logic signed [P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;
endmodule

// ===== design/sps_div.sv =====
`timescale 1ns / 1ps
module sps_div
	import sps_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [NUM_W-1:0] dividend,
	input  logic [D_W-1:0]   divisor,
	output logic             ready,
	output logic [NUM_W-1:0] quotient
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W:0]     trial;
	logic             fits;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		fits  = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? D_W'(trial - {1'b0, divisor}) : trial[D_W-1:0];
		end
	end

	assign ready    = cnt_q == '0;
	assign quotient = quo_q;
endmodule

// ===== design/sor_poisson_grid_solver.sv =====
`timescale 1ns / 1ps
// channel  | ports                        | handshake
// ---------+------------------------------+----------------------------------
// command  | start, busy, cmd (cmd_t)     | word taken when start && !busy
// result   | done, result (res_t)         | one-cycle strobe, cannot stall
// config   | cfg_write, cfg_index, cfg_data | written on any edge with cfg_write
//
// Write and unused-op words pass ST_WRITE or ST_NOP, reads ST_READ and
// ST_READ_WAIT, before the result strobe. A solve runs ST_SETUP, then per sweep
// each node reads in ST_RD0 to ST_RD5, uses the shared multiplier and divide
// load in ST_M1 to ST_M6, divides bit-serially in ST_DIV and writes back in
// ST_FIN. busy is high from acceptance until the result strobe. Reset clears
// control state only; node and source memories hold nothing defined until
// written. No backpressure on the result side.
module sor_poisson_grid_solver
	import sps_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	output logic             done,
	output res_t             result,
	input  logic             cfg_write,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	localparam int SIDE   = MAX_STEPS + 1;
	localparam int DEPTH  = SIDE * SIDE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int VB_EFF = VALUE_BITS < 32 ? VALUE_BITS : 32;

	function automatic logic [31:0] sat_vb(input logic signed [71:0] x);
		logic signed [71:0] hi;
		logic signed [71:0] lo;
		hi = (72'sd1 <<< (VB_EFF - 1)) - 72'sd1;
		lo = -hi - 72'sd1;
		if (x > hi) return hi[31:0];
		if (x < lo) return lo[31:0];
		return x[31:0];
	endfunction

	// configuration
	logic [STEP_W-1:0] rows_q, cols_q;
	logic [16:0]       omega_q;
	logic [30:0]       tol_q;
	logic [15:0]       max_sweeps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q       <= 7'd64;
			cols_q       <= 7'd64;
			omega_q      <= 17'd130632;
			tol_q        <= 31'd66;
			max_sweeps_q <= 16'd1000;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROWS:      rows_q       <= cfg_data[6:0];
				REG_COLS:      cols_q       <= cfg_data[6:0];
				REG_OMEGA:     omega_q      <= cfg_data[16:0];
				REG_TOLERANCE: tol_q        <= cfg_data;
				REG_MAX_SWEEP: max_sweeps_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;

	cmd_t              cmd_q;
	logic [STEP_W-1:0] rs_q, cs_q, r_q, rmax_q;
	logic [STEP_W:0]   d_q;
	logic [R2_W-1:0]   r2_q, c2_q;
	logic [D_W-1:0]    dval_q;
	logic [15:0]       limit_q, sweeps_q;
	logic [ADDR_W-1:0] addr_q;
	logic signed [31:0] old_q, f_q, up_q, dn_q, lf_q, rt_q;
	logic signed [S_W-1:0] s_q;
	logic signed [36:0] a_q;
	logic [P_W-1:0]    plo_q;
	logic [30:0]       eps_q;
	res_t              result_q;
	logic              done_q;

	// memories and shared units
	logic              node_we, src_we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [31:0]       node_wdata, node_rd, src_rd;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [P_W-1:0]  mul_p;
	logic              div_load, div_ready;
	logic [NUM_W-1:0]  div_num, div_q;

	sps_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(waddr), .wdata(node_wdata),
		.raddr(raddr), .rdata(node_rd)
	);

	sps_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_src_ram (
		.clk(clk), .we(src_we), .waddr(waddr), .wdata(sat_vb(72'(cmd_q.source_in))),
		.raddr(raddr), .rdata(src_rd)
	);

	sps_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	sps_div u_div (
		.clk(clk), .arst_n(arst_n), .load(div_load), .dividend(div_num),
		.divisor(dval_q), .ready(div_ready), .quotient(div_q)
	);

	// address of a single-node access
	logic              io_ok;
	logic [ADDR_W-1:0] io_addr;
	assign io_ok   = (32'(cmd_q.row) <= MAX_STEPS) && (32'(cmd_q.col) <= MAX_STEPS);
	assign io_addr = ADDR_W'(32'(cmd_q.row) * SIDE + 32'(cmd_q.col));

	// sweep geometry
	logic [STEP_W:0]   last_d;
	logic [STEP_W:0]   r0, rmax_d;
	logic [STEP_W-1:0] r_clamp, c_clamp;
	assign last_d = STEP_W'(rs_q) + cs_q - 2'd2;
	assign r0     = (d_q > cs_q - 1'b1) ? d_q - (cs_q - 1'b1) : (STEP_W+1)'(1);
	assign rmax_d = (d_q - 1'b1 < rs_q - 1'b1) ? d_q - 1'b1 : (STEP_W+1)'(rs_q - 1'b1);

	always_comb begin
		r_clamp = rows_q;
		if (rows_q < 7'd2) r_clamp = 7'd2;
		else if (32'(rows_q) > MAX_STEPS) r_clamp = STEP_W'(MAX_STEPS);
		c_clamp = cols_q;
		if (cols_q < 7'd2) c_clamp = 7'd2;
		else if (32'(cols_q) > MAX_STEPS) c_clamp = STEP_W'(MAX_STEPS);
	end

	// |S| for the relaxed term
	logic              s_neg;
	logic [S_W-1:0]    s_mag;
	assign s_neg = s_q[S_W-1];
	assign s_mag = s_neg ? S_W'(-s_q) : S_W'(s_q);

	// rounding of (1-w)*old / 2^16, ties away from zero
	logic              a_neg;
	logic [P_W-1:0]    a_mag;
	logic [36:0]       a_rnd;
	assign a_neg = mul_p[P_W-1];
	assign a_mag = a_neg ? P_W'(-mul_p) : P_W'(mul_p);
	assign a_rnd = 37'((a_mag + P_W'(32768)) >> 16);

	assign div_num = NUM_W'(plo_q) + (NUM_W'($unsigned(mul_p)) << 32) + NUM_W'(dval_q >> 1);

	// new value and change
	logic signed [71:0] b_val, sum_val;
	logic [31:0]        nv;
	logic signed [32:0] diff;
	logic [32:0]        dmag;
	logic [30:0]        change;
	always_comb begin
		b_val   = s_neg ? -$signed(72'(div_q)) : $signed(72'(div_q));
		sum_val = b_val + 72'(a_q);
		nv      = sat_vb(sum_val);
		diff    = 33'(old_q) - 33'($signed(nv));
		dmag    = diff[32] ? 33'(-diff) : 33'(diff);
		change  = (dmag > 33'h7FFFFFFF) ? 31'h7FFFFFFF : dmag[30:0];
	end

	logic sweep_conv, sweep_last;
	assign sweep_conv = eps_q < tol_q;
	assign sweep_last = sweeps_q + 1'b1 == limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic finish;

	always_comb begin
		state_d    = state_q;
		node_we    = 1'b0;
		src_we     = 1'b0;
		waddr      = addr_q;
		raddr      = addr_q;
		node_wdata = nv;
		mul_a      = '0;
		mul_b      = '0;
		div_load   = 1'b0;
		finish     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (op_t'(cmd.operation))
						OP_WRITE: state_d = ST_WRITE;
						OP_SOLVE: state_d = ST_SETUP;
						OP_READ:  state_d = ST_READ;
						default:  state_d = ST_NOP;
					endcase
				end
			end
			ST_WRITE: begin
				node_we    = io_ok;
				src_we     = io_ok;
				waddr      = io_addr;
				node_wdata = sat_vb(72'(cmd_q.node_value_in));
				finish     = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_READ: begin
				raddr   = io_addr;
				state_d = ST_READ_WAIT;
			end
			ST_READ_WAIT, ST_NOP: begin
				finish  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SETUP: state_d = ST_DIAG;
			ST_DIAG:  state_d = (d_q > last_d) ? ST_SWEEP_END : ST_RD0;
			ST_RD0: state_d = ST_RD1;
			ST_RD1: begin
				raddr   = addr_q - ADDR_W'(SIDE);
				state_d = ST_RD2;
			end
			ST_RD2: begin
				raddr   = addr_q + ADDR_W'(SIDE);
				state_d = ST_RD3;
			end
			ST_RD3: begin
				raddr   = addr_q - 1'b1;
				state_d = ST_RD4;
			end
			ST_RD4: begin
				raddr   = addr_q + 1'b1;
				state_d = ST_RD5;
			end
			ST_RD5: state_d = ST_M1;
			ST_M1: begin
				mul_a   = MA_W'(up_q) + MA_W'(dn_q);
				mul_b   = $signed(MB_W'(r2_q));
				state_d = ST_M2;
			end
			ST_M2: begin
				mul_a   = MA_W'(lf_q) + MA_W'(rt_q);
				mul_b   = $signed(MB_W'(c2_q));
				state_d = ST_M3;
			end
			ST_M3: begin
				mul_a   = MA_W'(old_q);
				mul_b   = 18'sd65536 - $signed({1'b0, omega_q});
				state_d = ST_M4;
			end
			ST_M4: begin
				mul_a   = $signed(MA_W'(s_mag[31:0]));
				mul_b   = $signed(MB_W'(omega_q));
				state_d = ST_M5;
			end
			ST_M5: begin
				mul_a   = $signed(MA_W'(s_mag[S_W-1:32]));
				mul_b   = $signed(MB_W'(omega_q));
				state_d = ST_M6;
			end
			ST_M6: begin
				div_load = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: if (div_ready) state_d = ST_FIN;
			ST_FIN: begin
				node_we = 1'b1;
				state_d = (r_q == rmax_q) ? ST_DIAG : ST_RD0;
			end
			ST_SWEEP_END: begin
				if (sweep_conv || sweep_last) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DIAG;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (start) cmd_q <= cmd;
			ST_WRITE, ST_NOP: result_q <= '0;
			ST_READ_WAIT: begin
				result_q <= '{node_value_out: io_ok ? node_rd : '0, sweeps_done: '0,
					last_change: '0, converged: 1'b0};
			end
			ST_SETUP: begin
				rs_q     <= r_clamp;
				cs_q     <= c_clamp;
				r2_q     <= R2_W'(r_clamp * r_clamp);
				c2_q     <= R2_W'(c_clamp * c_clamp);
				dval_q   <= D_W'((32'(r_clamp) * r_clamp + 32'(c_clamp) * c_clamp) << 1);
				limit_q  <= (max_sweeps_q == '0) ? 16'd1 : max_sweeps_q;
				sweeps_q <= '0;
				d_q      <= (STEP_W+1)'(2);
				eps_q    <= '0;
			end
			ST_DIAG: begin
				r_q    <= STEP_W'(r0);
				rmax_q <= STEP_W'(rmax_d);
				addr_q <= ADDR_W'(32'(r0) * SIDE + 32'(d_q - r0));
			end
			ST_RD1: begin
				old_q <= node_rd;
				f_q   <= src_rd;
			end
			ST_RD2: up_q <= node_rd;
			ST_RD3: dn_q <= node_rd;
			ST_RD4: lf_q <= node_rd;
			ST_RD5: rt_q <= node_rd;
			ST_M2: s_q <= S_W'(f_q) + S_W'(mul_p);
			ST_M3: s_q <= s_q + S_W'(mul_p);
			ST_M4: a_q <= a_neg ? -$signed(a_rnd) : $signed(a_rnd);
			ST_M5: plo_q <= mul_p;
			ST_FIN: begin
				if (change > eps_q) eps_q <= change;
				if (r_q == rmax_q) begin
					d_q <= d_q + 1'b1;
				end else begin
					r_q    <= r_q + 1'b1;
					addr_q <= addr_q + ADDR_W'(SIDE - 1);
				end
			end
			ST_SWEEP_END: begin
				sweeps_q <= sweeps_q + 1'b1;
				eps_q    <= '0;
				d_q      <= (STEP_W+1)'(2);
				result_q <= '{node_value_out: '0, sweeps_done: sweeps_q + 1'b1,
					last_change: eps_q, converged: sweep_conv};
			end
			default: ;
		endcase
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;
endmodule

// ===== design/sps_checker.sv =====
`timescale 1ns / 1ps
module sps_checker
	import sps_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t result
);
	a_take_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after accepted word");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	// only a solve reports sweeps; everything else leaves status fields clear
	a_nonsolve_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.sweeps_done == 16'd0 |-> !result.converged && result.last_change == '0)
		else $error("status fields set on non-solve result");
endmodule

bind sor_poisson_grid_solver sps_checker u_sps_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .result(result)
);

// ===== tb/sv/grid_solver_checker.sv =====
`timescale 1ns / 1ps
module grid_solver_checker
	import sps_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  cmd_t             cmd,
	input  logic             done,
	input  res_t             result,
	input  logic             cfg_write,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             end_check,
	output int               fail_count
);

	localparam int SIDE  = 65;
	localparam int STEPS = 64;

	int          node_val[SIDE*SIDE];
	int          node_src[SIDE*SIDE];
	logic [30:0] sweep_change;
	logic [6:0]  rows_q, cols_q;
	logic [16:0] omega_q;
	logic [30:0] tol_q;
	logic [15:0] sweep_limit_q;
	res_t        pending_results[$];

	initial fail_count = 0;

	task automatic report(string what, longint got, longint want);
		$display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic longint round_scaled(longint x, longint k, longint d);
		longint m, q;
		m = (x < 0) ? -x : x;
		q = (m / d) * k + ((m % d) * k + d / 2) / d;
		return (x < 0) ? -q : q;
	endfunction

	function automatic int clamp_steps(int s);
		if (s < 2) return 2;
		if (s > STEPS) return STEPS;
		return s;
	endfunction

	// in-place update of one interior point, returns its change
	function automatic longint relax_point(int r, int c, longint r2, longint c2);
		int     i;
		longint old, s, a, b, nv, ch;
		i = r * SIDE + c;
		old = node_val[i];
		s = longint'(node_src[i])
			+ r2 * (longint'(node_val[i-SIDE]) + longint'(node_val[i+SIDE]))
			+ c2 * (longint'(node_val[i-1]) + longint'(node_val[i+1]));
		a = round_scaled((65536 - longint'(omega_q)) * old, 1, 65536);
		b = round_scaled(s, longint'(omega_q), 2 * (r2 + c2));
		nv = a + b;
		if (nv > 64'sh7FFFFFFF) nv = 64'sh7FFFFFFF;
		if (nv < -64'sh80000000) nv = -64'sh80000000;
		node_val[i] = int'(nv);
		ch = (old > nv) ? old - nv : nv - old;
		return (ch > 64'sh7FFFFFFF) ? 64'sh7FFFFFFF : ch;
	endfunction

	function automatic res_t solve_grid();
		res_t   res;
		int     rr, cc, limit, sweeps, d, r, rmax;
		longint r2, c2, eps, ch;
		logic   conv;
		res = '0;
		rr = clamp_steps(rows_q);
		cc = clamp_steps(cols_q);
		r2 = rr * rr;
		c2 = cc * cc;
		limit = (sweep_limit_q == 0) ? 1 : sweep_limit_q;
		sweeps = 0;
		conv = 1'b0;
		while (sweeps < limit) begin
			eps = 0;
			for (d = 2; d <= rr + cc - 2; d++) begin
				r = (d > cc - 1) ? d - (cc - 1) : 1;
				rmax = (d - 1 < rr - 1) ? d - 1 : rr - 1;
				for (; r <= rmax; r++) begin
					ch = relax_point(r, d - r, r2, c2);
					if (ch > eps) eps = ch;
				end
			end
			sweeps++;
			sweep_change = eps[30:0];
			if (eps < tol_q) begin
				conv = 1'b1;
				break;
			end
		end
		res.sweeps_done = sweeps[15:0];
		res.last_change = sweep_change;
		res.converged = conv;
		return res;
	endfunction

	function automatic res_t predict_word(cmd_t c);
		res_t res;
		res = '0;
		case (op_t'(c.operation))
			OP_WRITE: begin
				if (c.row <= STEPS && c.col <= STEPS) begin
					node_val[c.row*SIDE + c.col] = c.node_value_in;
					node_src[c.row*SIDE + c.col] = c.source_in;
				end
			end
			OP_READ: begin
				if (c.row <= STEPS && c.col <= STEPS)
					res.node_value_out = node_val[c.row*SIDE + c.col];
			end
			OP_SOLVE: res = solve_grid();
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			rows_q <= 7'd64;
			cols_q <= 7'd64;
			omega_q <= 17'd130632;
			tol_q <= 31'd66;
			sweep_limit_q <= 16'd1000;
			sweep_change <= '0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report("unexpected word", longint'(result.node_value_out), 0);
				end else begin
					want = pending_results.pop_front();
					if (result.node_value_out !== want.node_value_out)
						report("node_value_out", result.node_value_out, want.node_value_out);
					if (result.sweeps_done !== want.sweeps_done)
						report("sweeps_done", result.sweeps_done, want.sweeps_done);
					if (result.last_change !== want.last_change)
						report("last_change", result.last_change, want.last_change);
					if (result.converged !== want.converged)
						report("converged", result.converged, want.converged);
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_ROWS:      rows_q <= cfg_data[6:0];
					REG_COLS:      cols_q <= cfg_data[6:0];
					REG_OMEGA:     omega_q <= cfg_data[16:0];
					REG_TOLERANCE: tol_q <= cfg_data[30:0];
					REG_MAX_SWEEP: sweep_limit_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (start && !busy)
				pending_results.push_back(predict_word(cmd));
		end
	end

	always @(posedge end_check)
		if (pending_results.size() != 0)
			report("words never returned", pending_results.size(), 0);

endmodule

// ===== tb/sv/tb_sor_poisson_grid_solver.sv =====
`timescale 1ns / 1ps
module tb_sor_poisson_grid_solver;
	import sps_pkg::*;

	localparam int QUIET_LIMIT = 400000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	cmd_t             cmd;
	logic             done;
	res_t             result;
	logic             cfg_write;
	logic [2:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             end_check;
	int               fail_count;

	int sent_count, rcv_count, quiet_cycles;
	int n_write, n_read, n_solve, n_cfg;
	int grid_r, grid_c, idle_pct;
	bit written[65][65];

	sor_poisson_grid_solver dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_write(cfg_write),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	grid_solver_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_write(cfg_write),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.end_check(end_check), .fail_count(fail_count)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		if (done) rcv_count <= rcv_count + 1;
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// call right after a rising edge; returns at the accepting edge, or after a random idle gap when idle_pct > 0
	task automatic send_word(logic [1:0] op, int r, int c, int v, int f);
		start <= 1'b1;
		cmd <= '{operation: op, row: r[6:0], col: c[6:0],
			node_value_in: v, source_in: f};
		do @(posedge clk); while (busy);
		sent_count++;
		case (op_t'(op))
			OP_WRITE: begin
				n_write++;
				if (r <= 64 && c <= 64) written[r][c] = 1'b1;
			end
			OP_READ:  n_read++;
			OP_SOLVE: n_solve++;
			default: ;
		endcase
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		do @(posedge clk); while (rcv_count != sent_count);
		@(posedge clk);
	endtask

	task automatic configure(int r, int c, int om, int tol, int ms);
		int vals[5];
		vals = '{r, c, om, tol, ms};
		wait_drain();
		for (int i = 0; i < 5; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data <= vals[i][CFG_W-1:0];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		@(posedge clk);
		n_cfg++;
		grid_r = (r < 2) ? 2 : (r > 64) ? 64 : r;
		grid_c = (c < 2) ? 2 : (c > 64) ? 64 : c;
	endtask

	function automatic int rand_value();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(0, 200000) - 100000;
			default: return $urandom_range(0, 40000000) - 20000000;
		endcase
	endfunction

	// every point a solve touches must hold a written value
	task automatic fill_grid();
		for (int r = 0; r <= grid_r; r++)
			for (int c = 0; c <= grid_c; c++)
				send_word(OP_WRITE, r, c, rand_value(), rand_value());
	endtask

	task automatic random_word();
		int k, r, c;
		k = $urandom_range(99);
		if (k < 50) begin
			if ($urandom_range(9) == 0) begin
				r = $urandom_range(127);
				c = $urandom_range(127);
			end else begin
				r = $urandom_range(grid_r + 1);
				c = $urandom_range(grid_c + 1);
			end
			send_word(OP_WRITE, r, c, rand_value(), rand_value());
		end else if (k < 78) begin
			if ($urandom_range(7) == 0) begin
				r = $urandom_range(127, 65);
				c = $urandom_range(127);
			end else begin
				do begin
					r = $urandom_range(grid_r + 1);
					c = $urandom_range(grid_c + 1);
				end while (!written[r][c]);
			end
			send_word(OP_READ, r, c, $urandom(), $urandom());
		end else if (k < 93) begin
			send_word(OP_SOLVE, $urandom_range(127), $urandom_range(127), $urandom(), $urandom());
		end else begin
			send_word(OP_NONE, $urandom_range(127), $urandom_range(127), $urandom(), $urandom());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		end_check = 1'b0;
		sent_count = 0;
		rcv_count = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		grid_r = 64;
		grid_c = 64;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, out-of-store addresses, unused op, limits
		configure(2, 2, 65536, 0, 3);
		for (int r = 0; r <= 2; r++)
			for (int c = 0; c <= 2; c++)
				send_word(OP_WRITE, r, c, ((r + c) % 2) ? 32'h7FFFFFFF : 32'h80000000,
					(c == 1) ? 32'h80000000 : 32'h7FFFFFFF);
		send_word(OP_READ, 0, 0, 0, 0);
		send_word(OP_READ, 2, 2, -1, -1);
		send_word(OP_WRITE, 127, 64, -1, -1);
		send_word(OP_WRITE, 64, 127, -1, -1);
		send_word(OP_WRITE, 64, 64, 32'h12345678, -5);
		send_word(OP_READ, 64, 64, 0, 0);
		send_word(OP_READ, 65, 0, 0, 0);
		send_word(OP_READ, 0, 127, 0, 0);
		send_word(OP_NONE, 127, 127, -1, -1);
		send_word(OP_SOLVE, 0, 0, 0, 0);
		send_word(OP_READ, 1, 1, 0, 0);
		configure(0, 1, 0, 32'h7FFFFFFF, 0);
		send_word(OP_SOLVE, 0, 0, 0, 0);
		configure(2, 2, 131071, 66, 4);
		send_word(OP_SOLVE, 0, 0, 0, 0);
		send_word(OP_READ, 1, 1, 0, 0);

		// tall and wide grids at the store limit
		configure(127, 1, 130632, 66, 2);
		fill_grid();
		send_word(OP_SOLVE, 0, 0, 0, 0);
		configure(2, 64, 98304, 1000, 2);
		fill_grid();
		send_word(OP_SOLVE, 0, 0, 0, 0);
		// full sweep limit; zero relaxation settles in the first sweep
		configure(2, 64, 0, 32'h7FFFFFFF, 65535);
		send_word(OP_SOLVE, 0, 0, 0, 0);
		send_word(OP_READ, 1, 33, 0, 0);

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 29 : (ph == 1) ? 69 : 0;
			for (int sub = 0; sub < 2; sub++) begin
				configure(($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(4, 2),
					$urandom_range(4, 2),
					($urandom_range(3) == 0) ? $urandom() : $urandom_range(131071, 60000),
					($urandom_range(2) == 0) ? $urandom() : $urandom_range(2000),
					$urandom_range(6, 1));
				fill_grid();
				for (int i = 0; i < 14; i++) random_word();
			end
		end

		wait_drain();
		repeat (8) @(posedge clk);
		end_check <= 1'b1;
		repeat (2) @(posedge clk);
		$display("covered %0d writes, %0d reads, %0d solves over %0d register settings",
			n_write, n_read, n_solve, n_cfg);
		$display("grid sizes 2..64 incl. clamped, omega and tolerance extremes, idle gaps");
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
